// ----- rtl/led_channel_calibrate_normalize_assert.svh -----
// assertion macros for the led channel calibrate/normalize block
// used by the port checker, no other dependencies
`ifndef LED_CHANNEL_CALIBRATE_NORMALIZE_ASSERT_SVH
`define LED_CHANNEL_CALIBRATE_NORMALIZE_ASSERT_SVH

// same-cycle implication
`define LCCN_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCCN_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lccn_pkg.sv -----
// shared types and constants for the led channel calibrate/normalize block
// no dependencies
`timescale 1ns / 1ps

package lccn_pkg;

    localparam int NumCh   = 5;
    localparam int LvlW    = 8;
    localparam int WideW   = 16;
    localparam int MulW    = WideW + LvlW;
    localparam int QuotW   = 8;
    localparam int NumDiv  = QuotW;
    localparam int CfgIdxW = 3;
    localparam int LutSize = 256;

    localparam logic [LvlW-1:0]  FactorFull = 8'd255;
    localparam logic [WideW-1:0] GainReset  = 16'd257;
    localparam logic [WideW-1:0] Dividend   = 16'hFFFF;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgRed   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgGreen = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgBlue  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCold  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgWarm  = 3'd4;

    typedef logic [LvlW-1:0]  lvl_t;
    typedef logic [WideW-1:0] wide_t;

    typedef wide_t [NumCh-1:0] cal_vec_t;
    typedef lvl_t  [NumCh-1:0] lvl_vec_t;

    typedef struct packed {
        lvl_t red_in;
        lvl_t green_in;
        lvl_t blue_in;
        lvl_t cold_in;
        lvl_t warm_in;
    } in_item_t;

    typedef struct packed {
        lvl_t red_out;
        lvl_t green_out;
        lvl_t blue_out;
        lvl_t cold_out;
        lvl_t warm_out;
    } out_item_t;

    // load strobes for the two lane stages
    typedef struct packed {
        logic ld1;
        logic ld2;
    } lane_ctl_t;

    // one stage of the merge pipeline
    typedef struct packed {
        cal_vec_t         v;
        wide_t            mx;
        wide_t            rem;
        logic [QuotW-1:0] quot;
    } div_stage_t;

endpackage

// ----- rtl/lccn_lane.sv -----
// one calibration lane: common gain then per-channel factor, two stages
// depends on lccn_pkg
`timescale 1ns / 1ps

module lccn_lane (
    input  logic                aclk,
    input  lccn_pkg::lane_ctl_t ctl,
    input  lccn_pkg::lvl_t      level,
    input  lccn_pkg::lvl_t      factor,
    input  lccn_pkg::wide_t     gain,
    output lccn_pkg::wide_t     cal
);

    logic [lccn_pkg::MulW-1:0] lift_prod;
    logic [lccn_pkg::MulW-1:0] scale_prod;
    lccn_pkg::wide_t           lift_reg;
    lccn_pkg::wide_t           lift_next;
    lccn_pkg::wide_t           cal_reg;
    lccn_pkg::wide_t           cal_next;

    always_comb begin
        lift_prod = lccn_pkg::MulW'(level) * lccn_pkg::MulW'(gain);
        lift_next = lift_prod[lccn_pkg::MulW-1:lccn_pkg::LvlW];
    end

    always_comb begin
        scale_prod = lccn_pkg::MulW'(lift_reg) * lccn_pkg::MulW'(factor);
        if (factor == '0) begin
            cal_next = '0;
        end else if (factor == lccn_pkg::FactorFull) begin
            cal_next = lift_reg;
        end else begin
            cal_next = scale_prod[lccn_pkg::MulW-1:lccn_pkg::LvlW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            lift_reg <= lift_next;
        end
        if (ctl.ld2) begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

// ----- rtl/lccn_merge.sv -----
// merge stage: maximum over lanes, bit-serial pipelined 65535/max, attenuation
// depends on lccn_pkg
`timescale 1ns / 1ps

module lccn_merge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lccn_pkg::cal_vec_t cal,
    output logic               out_valid,
    input  logic               out_ready,
    output lccn_pkg::lvl_vec_t out_lvl
);

    localparam int NumStg = lccn_pkg::NumDiv + 1;
    localparam int RemW   = lccn_pkg::WideW + lccn_pkg::QuotW;

    lccn_pkg::div_stage_t stg_reg  [NumStg];
    lccn_pkg::div_stage_t stg_next [NumStg];
    logic [NumStg-1:0]    vld_reg;
    logic [NumStg-1:0]    vld_next;
    logic [NumStg:0]      can;
    lccn_pkg::wide_t      mx;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    lccn_pkg::lvl_vec_t   out_lvl_reg;
    lccn_pkg::lvl_vec_t   out_lvl_next;
    logic                 big;
    logic [lccn_pkg::MulW-1:0] att_prod [lccn_pkg::NumCh];

    // stall chain, a stage loads when empty or when the next one moves
    always_comb begin
        can[NumStg] = !out_vld_reg || out_ready;
        for (int k = NumStg - 1; k >= 0; k--) begin
            can[k] = !vld_reg[k] || can[k+1];
        end
        vld_next[0] = can[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NumStg; k++) begin
            vld_next[k] = can[k] ? vld_reg[k-1] : vld_reg[k];
        end
        out_vld_next = can[NumStg] ? vld_reg[NumStg-1] : out_vld_reg;
    end

    // largest calibrated value
    always_comb begin
        mx = '0;
        for (int i = 0; i < lccn_pkg::NumCh; i++) begin
            if (cal[i] > mx) begin
                mx = cal[i];
            end
        end
        stg_next[0].v    = cal;
        stg_next[0].mx   = mx;
        stg_next[0].rem  = lccn_pkg::Dividend;
        stg_next[0].quot = '0;
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 1; k < NumStg; k++) begin : g_div
        localparam int Bit = lccn_pkg::NumDiv - k;
        logic [RemW-1:0] shifted;

        always_comb begin
            shifted     = {{lccn_pkg::QuotW{1'b0}}, stg_reg[k-1].mx} << Bit;
            stg_next[k] = stg_reg[k-1];
            if ({{lccn_pkg::QuotW{1'b0}}, stg_reg[k-1].rem} >= shifted) begin
                stg_next[k].rem       = stg_reg[k-1].rem - shifted[lccn_pkg::WideW-1:0];
                stg_next[k].quot[Bit] = 1'b1;
            end
        end
    end

    // attenuate only when some lane went above full scale
    always_comb begin
        big = |stg_reg[NumStg-1].mx[lccn_pkg::WideW-1:lccn_pkg::LvlW];
        for (int i = 0; i < lccn_pkg::NumCh; i++) begin
            att_prod[i] = lccn_pkg::MulW'(stg_reg[NumStg-1].v[i])
                        * lccn_pkg::MulW'(stg_reg[NumStg-1].quot);
            out_lvl_next[i] = big ? att_prod[i][lccn_pkg::WideW-1:lccn_pkg::LvlW]
                                  : stg_reg[NumStg-1].v[i][lccn_pkg::LvlW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && can[0]) begin
            stg_reg[0] <= stg_next[0];
        end
        for (int k = 1; k < NumStg; k++) begin
            if (vld_reg[k-1] && can[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (vld_reg[NumStg-1] && can[NumStg]) begin
            out_lvl_reg <= out_lvl_next;
        end
    end

    assign in_ready  = can[0];
    assign out_valid = out_vld_reg;
    assign out_lvl   = out_lvl_reg;

endmodule

// ----- rtl/led_channel_calibrate_normalize.sv -----
// Five-channel LED level calibration and normalization.
// Input channel s_valid/s_ready/s_data carries one color per transfer
// (red, green, blue, cold white, warm white, 8 bits each); the result
// channel m_valid/m_ready/m_data returns one calibrated color per transfer.
// Factors are written on cfg_we/cfg_index/cfg_wdata (index 0..4 = red,
// green, blue, cold, warm); other indexes are dropped. Write only when idle.
// From input transfer to m_valid a color passes two lane stages, one
// max stage, eight divider stages (one quotient bit each) and the output
// register. Throughput is one color per cycle while m_ready holds no
// result back; every stage is a register with its own valid so bubbles
// collapse and a new color is taken while a finished one waits on m_ready.
// Reset (aresetn low, synchronous) empties the pipeline, sets all factors
// to 255 and the common gain to 257. While the receiver stalls the result
// holds on m_data and the pipeline keeps filling until full, then s_ready
// drops.
// Depends on lccn_pkg, lccn_lane, lccn_merge.
`timescale 1ns / 1ps

module led_channel_calibrate_normalize (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lccn_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lccn_pkg::out_item_t              m_data,
    input  logic                             cfg_we,
    input  logic [lccn_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [lccn_pkg::LvlW-1:0]        cfg_wdata
);

    // factor registers and the common gain derived from them
    lccn_pkg::lvl_t  factor_reg  [lccn_pkg::NumCh];
    lccn_pkg::lvl_t  factor_next [lccn_pkg::NumCh];
    lccn_pkg::wide_t gain_reg;
    lccn_pkg::wide_t gain_next;
    lccn_pkg::lvl_t  lowest;
    lccn_pkg::wide_t gain_lut [lccn_pkg::LutSize];

    // lane pipeline control
    logic                v1_vld_reg;
    logic                v1_vld_next;
    logic                v2_vld_reg;
    logic                v2_vld_next;
    logic                can1;
    logic                can2;
    logic                merge_ready;
    lccn_pkg::lane_ctl_t lane_ctl;

    // datapath
    lccn_pkg::lvl_t     lvl_in [lccn_pkg::NumCh];
    lccn_pkg::cal_vec_t cal_val;
    lccn_pkg::lvl_vec_t out_lvl;

    // gain table 65535 / f, filled at elaboration; entry 0 is never selected
    assign gain_lut[0] = lccn_pkg::Dividend;
    for (genvar g = 1; g < lccn_pkg::LutSize; g++) begin : g_gain
        localparam logic [lccn_pkg::WideW-1:0] GainVal =
            lccn_pkg::WideW'(32'(lccn_pkg::Dividend) / g);
        assign gain_lut[g] = GainVal;
    end

    // register write and gain update in the same edge
    always_comb begin
        for (int i = 0; i < lccn_pkg::NumCh; i++) begin
            factor_next[i] = factor_reg[i];
        end
        if (cfg_we) begin
            unique case (cfg_index) inside
                lccn_pkg::CfgRed, lccn_pkg::CfgGreen, lccn_pkg::CfgBlue,
                lccn_pkg::CfgCold, lccn_pkg::CfgWarm: begin
                    factor_next[cfg_index] = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
        // smallest enabled factor, full scale when none is lower
        lowest = lccn_pkg::FactorFull;
        for (int i = 0; i < lccn_pkg::NumCh; i++) begin
            if (factor_next[i] != '0 && factor_next[i] < lowest) begin
                lowest = factor_next[i];
            end
        end
        gain_next = gain_lut[lowest];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lccn_pkg::NumCh; i++) begin
                factor_reg[i] <= lccn_pkg::FactorFull;
            end
            gain_reg <= lccn_pkg::GainReset;
        end else begin
            for (int i = 0; i < lccn_pkg::NumCh; i++) begin
                factor_reg[i] <= factor_next[i];
            end
            gain_reg <= gain_next;
        end
    end

    // lane stages: each loads when empty or when its successor moves
    always_comb begin
        can2         = !v2_vld_reg || merge_ready;
        can1         = !v1_vld_reg || can2;
        lane_ctl.ld1 = s_valid && can1;
        lane_ctl.ld2 = v1_vld_reg && can2;
        v1_vld_next  = can1 ? s_valid : v1_vld_reg;
        v2_vld_next  = can2 ? v1_vld_reg : v2_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_vld_reg <= 1'b0;
            v2_vld_reg <= 1'b0;
        end else begin
            v1_vld_reg <= v1_vld_next;
            v2_vld_reg <= v2_vld_next;
        end
    end

    assign s_ready = can1;

    always_comb begin
        lvl_in[0] = s_data.red_in;
        lvl_in[1] = s_data.green_in;
        lvl_in[2] = s_data.blue_in;
        lvl_in[3] = s_data.cold_in;
        lvl_in[4] = s_data.warm_in;
    end

    // one calibration lane per channel
    for (genvar i = 0; i < lccn_pkg::NumCh; i++) begin : g_lane
        lccn_lane u_lane (
            .aclk   (aclk),
            .ctl    (lane_ctl),
            .level  (lvl_in[i]),
            .factor (factor_reg[i]),
            .gain   (gain_reg),
            .cal    (cal_val[i])
        );
    end

    // maximum, division, attenuation and output register
    lccn_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_vld_reg),
        .in_ready  (merge_ready),
        .cal       (cal_val),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_lvl   (out_lvl)
    );

    always_comb begin
        m_data.red_out   = out_lvl[0];
        m_data.green_out = out_lvl[1];
        m_data.blue_out  = out_lvl[2];
        m_data.cold_out  = out_lvl[3];
        m_data.warm_out  = out_lvl[4];
    end

endmodule

// ----- rtl/lccn_checker.sv -----
// port-level checks for the calibrate/normalize block, bound to the top level
// depends on lccn_pkg and led_channel_calibrate_normalize_assert.svh
`timescale 1ns / 1ps
`include "led_channel_calibrate_normalize_assert.svh"

module lccn_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lccn_pkg::out_item_t m_data
);

    // a stalled result stays offered
    `LCCN_ASSERT_NXT(a_m_hold, aclk, !aresetn, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")

    // a stalled result keeps its value
    `LCCN_ASSERT_NXT(a_m_stable, aclk, !aresetn, m_valid && !m_ready, $stable(m_data), "m_data changed while stalled")

    // pipeline is empty right after reset
    `LCCN_ASSERT_NXT(a_rst_empty, aclk, 1'b0, !aresetn, !m_valid, "result offered after reset")

    // with no result waiting the pipeline can always take a transfer
    `LCCN_ASSERT_NOW(a_skid, aclk, !aresetn, !m_valid, s_ready, "s_ready low with empty output")

    // an offered input transfer stays up until it is taken
    `LCCN_ASSERT_NXT(a_s_hold, aclk, !aresetn, s_valid && !s_ready, s_valid, "s_valid dropped before transfer")

endmodule

bind led_channel_calibrate_normalize lccn_checker u_lccn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
